// ----- src/salcp_pkg.sv -----
// Shared types and constants for the suffix array and LCP builder.
`timescale 1ns / 1ps
`default_nettype none

package salcp_pkg;

    localparam int SYM_W    = 8;
    localparam int RANK_W   = 10;
    localparam int START_W  = 10;
    localparam int PREFIX_W = 11;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE,
        S_INIT_RD, S_INIT_WR,
        S_CLR, S_C1A, S_C1B, S_C1C, S_C1D,
        S_PA, S_PB,
        S_DA, S_DB, S_DC, S_DD,
        S_KTOP, S_F1, S_F2A, S_F2B,
        S_CPA, S_CPB,
        S_R0A, S_R0B, S_RBA, S_RBB, S_RBC, S_RBD, S_RBE, S_RBF, S_RDONE,
        S_FNA, S_FNB,
        S_KA, S_KB, S_KC, S_KD, S_KE, S_KF, S_KW
    } ctl_state_t;

    typedef enum logic [2:0] {
        I_HOLD, I_ZERO, I_ONE, I_INC, I_DEC, I_LOAD_N, I_LOAD_NK
    } i_op_t;

    typedef struct packed {
        ctl_state_t step;
        i_op_t      i_op;
    } sal_cmd_t;

    typedef struct packed {
        logic build_go;
        logic i_eq_n;
        logic i_eq_bk;
        logic i_zero;
        logic k_lt_n;
        logic deep;
        logic dist_ge_n;
        logic ri_zero;
        logic in_bounds;
        logic txt_eq;
    } sal_stat_t;

endpackage

`default_nettype wire

// ----- src/salcp_ctrl.sv -----
// Sequencer for loading, sorting passes and the common-prefix pass.
`timescale 1ns / 1ps
`default_nettype none

module salcp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire salcp_pkg::sal_stat_t stat,
    output salcp_pkg::sal_cmd_t       cmd
);
    import salcp_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       first_reg, first_next;
    i_op_t      i_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        i_op       = I_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                if (stat.build_go)
                begin
                    state_next = S_INIT_RD;
                    i_op       = I_ZERO;
                    first_next = 1'b1;
                end
            end
            S_INIT_RD:
            begin
                if (stat.i_eq_n)
                begin
                    state_next = S_CLR;
                    i_op       = I_ZERO;
                end
                else
                    state_next = S_INIT_WR;
            end
            S_INIT_WR:
            begin
                i_op       = I_INC;
                state_next = S_INIT_RD;
            end
            S_CLR:
            begin
                if (stat.i_eq_bk)
                begin
                    state_next = S_C1A;
                    i_op       = I_ZERO;
                end
                else
                    i_op = I_INC;
            end
            S_C1A:
            begin
                if (stat.i_eq_n)
                begin
                    state_next = S_PA;
                    i_op       = I_ZERO;
                end
                else
                    state_next = S_C1B;
            end
            S_C1B: state_next = S_C1C;
            S_C1C: state_next = S_C1D;
            S_C1D:
            begin
                i_op       = I_INC;
                state_next = S_C1A;
            end
            S_PA:
            begin
                if (stat.i_eq_bk)
                begin
                    state_next = S_DA;
                    i_op       = I_LOAD_N;
                end
                else
                    state_next = S_PB;
            end
            S_PB:
            begin
                i_op       = I_INC;
                state_next = S_PA;
            end
            S_DA:
            begin
                if (stat.i_zero)
                begin
                    if (first_reg)
                    begin
                        first_next = 1'b0;
                        state_next = S_KTOP;
                    end
                    else
                    begin
                        state_next = S_CPA;
                        i_op       = I_ZERO;
                    end
                end
                else
                    state_next = S_DB;
            end
            S_DB: state_next = S_DC;
            S_DC: state_next = S_DD;
            S_DD:
            begin
                i_op       = I_DEC;
                state_next = S_DA;
            end
            S_KTOP:
            begin
                if (stat.k_lt_n)
                begin
                    state_next = S_F1;
                    i_op       = I_LOAD_NK;
                end
                else
                begin
                    state_next = S_FNA;
                    i_op       = I_ZERO;
                end
            end
            S_F1:
            begin
                if (stat.i_eq_n)
                begin
                    state_next = S_F2A;
                    i_op       = I_ZERO;
                end
                else
                    i_op = I_INC;
            end
            S_F2A:
            begin
                if (stat.i_eq_n)
                begin
                    state_next = S_CLR;
                    i_op       = I_ZERO;
                end
                else
                    state_next = S_F2B;
            end
            S_F2B:
            begin
                i_op       = I_INC;
                state_next = S_F2A;
            end
            S_CPA:
            begin
                if (stat.i_eq_n)
                    state_next = S_R0A;
                else
                    state_next = S_CPB;
            end
            S_CPB:
            begin
                i_op       = I_INC;
                state_next = S_CPA;
            end
            S_R0A: state_next = S_R0B;
            S_R0B:
            begin
                i_op       = I_ONE;
                state_next = S_RBA;
            end
            S_RBA:
            begin
                if (stat.i_eq_n)
                    state_next = S_RDONE;
                else
                    state_next = S_RBB;
            end
            S_RBB: state_next = S_RBC;
            S_RBC: state_next = S_RBD;
            S_RBD:
            begin
                if (stat.deep)
                    state_next = S_RBE;
                else
                begin
                    i_op       = I_INC;
                    state_next = S_RBA;
                end
            end
            S_RBE: state_next = S_RBF;
            S_RBF:
            begin
                i_op       = I_INC;
                state_next = S_RBA;
            end
            S_RDONE:
            begin
                if (stat.dist_ge_n)
                begin
                    state_next = S_FNA;
                    i_op       = I_ZERO;
                end
                else
                    state_next = S_KTOP;
            end
            S_FNA:
            begin
                if (stat.i_eq_n)
                begin
                    state_next = S_KA;
                    i_op       = I_ZERO;
                end
                else
                    state_next = S_FNB;
            end
            S_FNB:
            begin
                i_op       = I_INC;
                state_next = S_FNA;
            end
            S_KA:
            begin
                if (stat.i_eq_n)
                    state_next = S_IDLE;
                else
                    state_next = S_KB;
            end
            S_KB:
            begin
                if (stat.ri_zero)
                begin
                    i_op       = I_INC;
                    state_next = S_KA;
                end
                else
                    state_next = S_KC;
            end
            S_KC: state_next = S_KD;
            S_KD: state_next = stat.in_bounds ? S_KE : S_KW;
            S_KE: state_next = S_KF;
            S_KF: state_next = stat.txt_eq ? S_KD : S_KW;
            S_KW:
            begin
                i_op       = I_INC;
                state_next = S_KA;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign cmd.step = state_reg;
    assign cmd.i_op = i_op;

endmodule

`default_nettype wire

// ----- src/salcp_datapath.sv -----
// Text, order, rank, bucket and prefix stores with their counters.
`timescale 1ns / 1ps
`default_nettype none

module salcp_datapath #(
    parameter int MAX_TEXT = 1024,
    parameter int ALPHABET = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire salcp_pkg::sal_cmd_t               cmd,
    output salcp_pkg::sal_stat_t                   stat,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              opcode,
    input  wire logic [salcp_pkg::SYM_W-1:0]       symbol,
    input  wire logic                              last_symbol,
    input  wire logic [salcp_pkg::RANK_W-1:0]      read_rank,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [salcp_pkg::START_W-1:0]          suffix_start,
    output logic [salcp_pkg::PREFIX_W-1:0]         common_prefix,
    output logic                                   out_of_range
);
    import salcp_pkg::*;

    localparam int NB = (ALPHABET > MAX_TEXT) ? ALPHABET : MAX_TEXT;
    localparam int AW = $clog2(MAX_TEXT);
    localparam int LW = $clog2(MAX_TEXT + 1);
    localparam int RW = $clog2(NB);
    localparam int BW = $clog2(NB + 1);
    localparam int KW = LW + 1;
    localparam int XW = ((BW > KW) ? BW : KW) + 1;
    localparam int CW = ((XW > RANK_W) ? XW : RANK_W) + 1;

    logic [SYM_W-1:0] text_mem [MAX_TEXT];
    logic [AW-1:0]    sa_mem   [MAX_TEXT];
    logic [RW-1:0]    rank_mem [MAX_TEXT];
    logic [RW-1:0]    sko_mem  [MAX_TEXT];
    logic [LW-1:0]    cnt_mem  [NB];
    logic [LW-1:0]    lcp_mem  [MAX_TEXT];

    logic [SYM_W-1:0] text_rd;
    logic [AW-1:0]    sa_rd;
    logic [RW-1:0]    rank_rd, sko_rd;
    logic [LW-1:0]    cnt_rd, lcp_rd;

    logic [AW-1:0] text_raddr, sa_raddr, rank_raddr, sko_raddr, lcp_raddr;
    logic [RW-1:0] cnt_raddr;
    logic          text_we, sa_we, rank_we, sko_we, cnt_we, lcp_we;
    logic [AW-1:0] text_waddr, sa_waddr, rank_waddr, sko_waddr, lcp_waddr;
    logic [RW-1:0] cnt_waddr;
    logic [SYM_W-1:0] text_wdata;
    logic [AW-1:0]    sa_wdata;
    logic [RW-1:0]    rank_wdata, sko_wdata;
    logic [LW-1:0]    cnt_wdata, lcp_wdata;

    // control registers
    logic [LW-1:0] len_reg, len_next;
    logic          built_reg, built_next;
    logic          pend_reg, pend_next;
    logic          ov_reg, ov_next;

    // working registers
    logic [LW-1:0] i_reg, i_next;
    logic [LW-1:0] t_reg, t_next;
    logic [KW-1:0] k_reg, k_next;
    logic [LW-1:0] h_reg, h_next;
    logic [LW-1:0] dist_reg, dist_next;
    logic [BW-1:0] bk_reg, bk_next;
    logic [LW-1:0] acc_reg, acc_next;
    logic [AW-1:0] p_reg, p_next;
    logic [RW-1:0] r_reg, r_next;
    logic [AW-1:0] a_reg, a_next;
    logic [AW-1:0] b_reg, b_next;
    logic [RW-1:0] oa_reg, oa_next;
    logic [AW-1:0] ri_reg, ri_next;
    logic [AW-1:0] j_reg, j_next;
    logic [SYM_W-1:0] ta_reg, ta_next;
    logic          poor_reg, poor_next;
    logic [AW-1:0] prank_reg, prank_next;
    logic [START_W-1:0]  ss_reg, ss_next;
    logic [PREFIX_W-1:0] cp_reg, cp_next;
    logic          oor_reg, oor_next;

    logic          in_fire, out_load;
    logic [LW-1:0] len_eff;
    logic          room;
    logic [RW-1:0] sat_sym;
    logic          same0, ain, bin, same_fin;
    logic [XW-1:0] sum_ak, sum_bk, sum_ih, sum_jh;

    // stores: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (text_we)
            text_mem[text_waddr] <= text_wdata;
        text_rd <= text_mem[text_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sa_we)
            sa_mem[sa_waddr] <= sa_wdata;
        sa_rd <= sa_mem[sa_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
            rank_mem[rank_waddr] <= rank_wdata;
        rank_rd <= rank_mem[rank_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sko_we)
            sko_mem[sko_waddr] <= sko_wdata;
        sko_rd <= sko_mem[sko_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        cnt_rd <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lcp_we)
            lcp_mem[lcp_waddr] <= lcp_wdata;
        lcp_rd <= lcp_mem[lcp_raddr];
    end

    assign in_stall = (cmd.step != S_IDLE) || pend_reg;
    assign in_fire  = in_valid && !in_stall;
    assign out_load = pend_reg && (!ov_reg || !out_stall);

    assign len_eff = built_reg ? '0 : len_reg;
    assign room    = len_eff < LW'(MAX_TEXT);
    assign sat_sym = ({1'b0, text_rd} >= 9'(ALPHABET)) ? RW'(ALPHABET - 1) : RW'(text_rd);

    assign sum_ak = XW'(a_reg) + XW'(k_reg);
    assign sum_bk = XW'(b_reg) + XW'(k_reg);
    assign sum_ih = XW'(i_reg) + XW'(h_reg);
    assign sum_jh = XW'(j_reg) + XW'(h_reg);
    assign same0  = oa_reg == sko_rd;
    assign ain    = sum_ak < XW'(len_reg);
    assign bin    = sum_bk < XW'(len_reg);
    assign same_fin = same0 && !ain && !bin;

    assign stat.build_go  = in_fire && (opcode == OP_LOAD) && last_symbol;
    assign stat.i_eq_n    = i_reg == len_reg;
    assign stat.i_eq_bk   = XW'(i_reg) == XW'(bk_reg);
    assign stat.i_zero    = i_reg == '0;
    assign stat.k_lt_n    = XW'(k_reg) < XW'(len_reg);
    assign stat.deep      = same0 && ain && bin;
    assign stat.dist_ge_n = dist_reg >= len_reg;
    assign stat.ri_zero   = rank_rd == '0;
    assign stat.in_bounds = (sum_ih < XW'(len_reg)) && (sum_jh < XW'(len_reg));
    assign stat.txt_eq    = ta_reg == text_rd;

    always_comb
    begin
        text_raddr = AW'(i_reg);
        sa_raddr   = pend_reg ? prank_reg : AW'(read_rank);
        rank_raddr = AW'(i_reg);
        sko_raddr  = AW'(i_reg);
        cnt_raddr  = RW'(i_reg);
        lcp_raddr  = pend_reg ? prank_reg : AW'(read_rank);

        text_we = 1'b0; text_waddr = AW'(len_eff); text_wdata = symbol;
        sa_we   = 1'b0; sa_waddr   = AW'(cnt_rd - 1'b1); sa_wdata = p_reg;
        rank_we = 1'b0; rank_waddr = AW'(i_reg);  rank_wdata = sat_sym;
        sko_we  = 1'b0; sko_waddr  = AW'(i_reg);  sko_wdata  = RW'(i_reg);
        cnt_we  = 1'b0; cnt_waddr  = RW'(i_reg);  cnt_wdata  = '0;
        lcp_we  = 1'b0; lcp_waddr  = ri_reg;      lcp_wdata  = h_reg;

        len_next   = len_reg;
        built_next = built_reg;
        pend_next  = pend_reg;
        ov_next    = ov_reg;
        t_next     = t_reg;
        k_next     = k_reg;
        h_next     = h_reg;
        dist_next  = dist_reg;
        bk_next    = bk_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        r_next     = r_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        oa_next    = oa_reg;
        ri_next    = ri_reg;
        j_next     = j_reg;
        ta_next    = ta_reg;
        poor_next  = poor_reg;
        prank_next = prank_reg;
        ss_next    = ss_reg;
        cp_next    = cp_reg;
        oor_next   = oor_reg;

        // result register: refill from the pending read, else drain
        if (out_load)
        begin
            ov_next   = 1'b1;
            pend_next = 1'b0;
            ss_next   = poor_reg ? '0 : START_W'(sa_rd);
            cp_next   = poor_reg ? '0 : PREFIX_W'(lcp_rd);
            oor_next  = poor_reg;
        end
        else if (!out_stall)
            ov_next = 1'b0;

        case (cmd.i_op)
            I_HOLD:    i_next = i_reg;
            I_ZERO:    i_next = '0;
            I_ONE:     i_next = LW'(1);
            I_INC:     i_next = i_reg + 1'b1;
            I_DEC:     i_next = i_reg - 1'b1;
            I_LOAD_N:  i_next = len_reg;
            I_LOAD_NK: i_next = LW'(XW'(len_reg) - XW'(k_reg));
            default:   i_next = i_reg;
        endcase

        case (cmd.step)
            S_IDLE:
            begin
                if (in_fire && (opcode == OP_LOAD))
                begin
                    built_next = 1'b0;
                    text_we    = room;
                    len_next   = room ? len_eff + 1'b1 : len_eff;
                    if (last_symbol)
                    begin
                        bk_next = BW'(ALPHABET);
                        k_next  = KW'(1);
                    end
                end
                else if (in_fire)
                begin
                    pend_next  = 1'b1;
                    prank_next = AW'(read_rank);
                    poor_next  = !built_reg || (CW'(read_rank) >= CW'(len_reg));
                end
            end
            S_INIT_WR:
            begin
                rank_we = 1'b1;
                sko_we  = 1'b1;
            end
            S_CLR:
                cnt_we = !stat.i_eq_bk;
            S_C1A:
            begin
                if (stat.i_eq_n)
                    acc_next = '0;
            end
            S_C1B: rank_raddr = AW'(sko_rd);
            S_C1C:
            begin
                r_next    = rank_rd;
                cnt_raddr = rank_rd;
            end
            S_C1D:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = r_reg;
                cnt_wdata = cnt_rd + 1'b1;
            end
            S_PB:
            begin
                acc_next  = acc_reg + cnt_rd;
                cnt_we    = 1'b1;
                cnt_wdata = acc_reg + cnt_rd;
            end
            S_DA: sko_raddr = AW'(i_reg - 1'b1);
            S_DB:
            begin
                p_next     = AW'(sko_rd);
                rank_raddr = AW'(sko_rd);
            end
            S_DC:
            begin
                r_next    = rank_rd;
                cnt_raddr = rank_rd;
            end
            S_DD:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = r_reg;
                cnt_wdata = cnt_rd - 1'b1;
                sa_we     = 1'b1;
            end
            S_KTOP: t_next = '0;
            S_F1:
            begin
                if (!stat.i_eq_n)
                begin
                    sko_we    = 1'b1;
                    sko_waddr = AW'(t_reg);
                    t_next    = t_reg + 1'b1;
                end
            end
            S_F2A: sa_raddr = AW'(i_reg);
            S_F2B:
            begin
                if (XW'(sa_rd) >= XW'(k_reg))
                begin
                    sko_we    = 1'b1;
                    sko_waddr = AW'(t_reg);
                    sko_wdata = RW'(XW'(sa_rd) - XW'(k_reg));
                    t_next    = t_reg + 1'b1;
                end
            end
            S_CPB:
            begin
                sko_we    = 1'b1;
                sko_wdata = rank_rd;
            end
            S_R0A: sa_raddr = '0;
            S_R0B:
            begin
                a_next     = sa_rd;
                dist_next  = LW'(1);
                rank_we    = 1'b1;
                rank_waddr = sa_rd;
                rank_wdata = '0;
            end
            S_RBA: sa_raddr = AW'(i_reg);
            S_RBB:
            begin
                b_next    = sa_rd;
                sko_raddr = a_reg;
            end
            S_RBC:
            begin
                oa_next   = sko_rd;
                sko_raddr = b_reg;
            end
            S_RBD:
            begin
                sko_raddr = AW'(sum_ak);
                if (!stat.deep)
                begin
                    rank_we    = 1'b1;
                    rank_waddr = b_reg;
                    rank_wdata = same_fin ? RW'(dist_reg - 1'b1) : RW'(dist_reg);
                    dist_next  = same_fin ? dist_reg : dist_reg + 1'b1;
                    a_next     = b_reg;
                end
            end
            S_RBE:
            begin
                oa_next   = sko_rd;
                sko_raddr = AW'(sum_bk);
            end
            S_RBF:
            begin
                rank_we    = 1'b1;
                rank_waddr = b_reg;
                rank_wdata = same0 ? RW'(dist_reg - 1'b1) : RW'(dist_reg);
                dist_next  = same0 ? dist_reg : dist_reg + 1'b1;
                a_next     = b_reg;
            end
            S_RDONE:
            begin
                if (!stat.dist_ge_n)
                begin
                    bk_next = BW'(dist_reg);
                    k_next  = k_reg << 1;
                end
            end
            S_FNA:
            begin
                sa_raddr = AW'(i_reg);
                if (stat.i_eq_n)
                begin
                    h_next    = '0;
                    lcp_we    = 1'b1;
                    lcp_waddr = '0;
                    lcp_wdata = '0;
                end
            end
            S_FNB:
            begin
                rank_we    = 1'b1;
                rank_waddr = sa_rd;
                rank_wdata = RW'(i_reg);
            end
            S_KA:
            begin
                if (stat.i_eq_n)
                    built_next = 1'b1;
                else if (h_reg != '0)
                    h_next = h_reg - 1'b1;
            end
            S_KB:
            begin
                ri_next  = AW'(rank_rd);
                sa_raddr = AW'(rank_rd - 1'b1);
            end
            S_KC: j_next = sa_rd;
            S_KD: text_raddr = AW'(sum_ih);
            S_KE:
            begin
                ta_next    = text_rd;
                text_raddr = AW'(sum_jh);
            end
            S_KF:
            begin
                if (stat.txt_eq)
                    h_next = h_reg + 1'b1;
            end
            S_KW: lcp_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            built_reg <= 1'b0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            len_reg   <= len_next;
            built_reg <= built_next;
            pend_reg  <= pend_next;
            ov_reg    <= ov_next;
            i_reg     <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        k_reg     <= k_next;
        h_reg     <= h_next;
        dist_reg  <= dist_next;
        bk_reg    <= bk_next;
        acc_reg   <= acc_next;
        p_reg     <= p_next;
        r_reg     <= r_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        oa_reg    <= oa_next;
        ri_reg    <= ri_next;
        j_reg     <= j_next;
        ta_reg    <= ta_next;
        poor_reg  <= poor_next;
        prank_reg <= prank_next;
        ss_reg    <= ss_next;
        cp_reg    <= cp_next;
        oor_reg   <= oor_next;
    end

    assign out_valid     = ov_reg;
    assign suffix_start  = ss_reg;
    assign common_prefix = cp_reg;
    assign out_of_range  = oor_reg;

endmodule

`default_nettype wire

// ----- src/suffix_array_lcp_builder_top.sv -----
// Top level of the suffix array and common-prefix builder.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Word contents
// in       receive    in_valid / in_stall  opcode, symbol, last_symbol, read_rank
// out      send       out_valid/out_stall  suffix_start, common_prefix, out_of_range
//
// A read word is held as a pending read and then moves into the output register
// once that is free, and the next word is taken as soon as it sits there.
// A load word with last_symbol set starts the build, during which in_stall is
// high: a counting pass over B buckets and N symbols, then at most ceil(log2(N))
// doubling rounds of reorder, counting and ranking passes, then a common-prefix
// pass; each store has a single read port.
// Reset clears the length, the built flag, the index counter and the handshake
// state only; the stores are written by each build before they are read.
// A stalled result holds in the output register; loads may continue beneath it.

module suffix_array_lcp_builder_top #(
    parameter int MAX_TEXT = 1024,
    parameter int ALPHABET = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              opcode,
    input  wire logic [salcp_pkg::SYM_W-1:0]       symbol,
    input  wire logic                              last_symbol,
    input  wire logic [salcp_pkg::RANK_W-1:0]      read_rank,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [salcp_pkg::START_W-1:0]          suffix_start,
    output logic [salcp_pkg::PREFIX_W-1:0]         common_prefix,
    output logic                                   out_of_range
);
    import salcp_pkg::*;

    sal_cmd_t  cmd;
    sal_stat_t stat;

    // sequencer: walks the sort and prefix passes
    salcp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // stores, counters and the word handshakes
    salcp_datapath #(
        .MAX_TEXT (MAX_TEXT),
        .ALPHABET (ALPHABET)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .symbol        (symbol),
        .last_symbol   (last_symbol),
        .read_rank     (read_rank),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .suffix_start  (suffix_start),
        .common_prefix (common_prefix),
        .out_of_range  (out_of_range)
    );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the suffix array and common-prefix builder.
`timescale 1ns / 1ps

module tb_top;

    import salcp_pkg::*;

    localparam int TEXT_CAP  = 1024;
    localparam int ITEM_GOAL = 1700;
    localparam int HOLD_LEN  = 400;

    typedef struct {
        logic [START_W-1:0]  start;
        logic [PREFIX_W-1:0] prefix;
        logic                oor;
    } entry_t;

    // One row of the directed table; typed rows carry their result inline.
    typedef struct {
        logic               op;
        logic [SYM_W-1:0]   sym;
        logic               last;
        logic [RANK_W-1:0]  rank;
        bit                 typed;
        entry_t             want;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                opcode;
    logic [SYM_W-1:0]    symbol;
    logic                last_symbol;
    logic [RANK_W-1:0]   read_rank;
    logic                out_valid;
    logic                out_stall;
    logic [START_W-1:0]  suffix_start;
    logic [PREFIX_W-1:0] common_prefix;
    logic                out_of_range;

    // Predictor copy of the block's state
    logic [SYM_W-1:0] text_mem [TEXT_CAP];
    int               text_len;
    bit               text_built;
    int               sa_pos  [TEXT_CAP];
    int               rank_of [TEXT_CAP];
    int               order2  [TEXT_CAP];
    int               lcp_of  [TEXT_CAP];

    entry_t pending_entries [$];
    int     errors;
    int     words_sent;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_req;
    int     hold_left;

    suffix_array_lcp_builder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .symbol       (symbol),
        .last_symbol  (last_symbol),
        .read_rank    (read_rank),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .suffix_start (suffix_start),
        .common_prefix(common_prefix),
        .out_of_range (out_of_range)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stable counting sort of order2 keyed by rank_of, into sa_pos
    function automatic void sort_by_rank(input int n, input int nb);
        int cnt [TEXT_CAP];
        int i;
        int p;
        for (i = 0; i < nb; i++)
            cnt[i] = 0;
        for (i = 0; i < n; i++)
            cnt[rank_of[order2[i]]]++;
        for (i = 1; i < nb; i++)
            cnt[i] += cnt[i - 1];
        for (i = n; i > 0; i--)
        begin
            p = order2[i - 1];
            cnt[rank_of[p]]--;
            sa_pos[cnt[rank_of[p]]] = p;
        end
    endfunction

    // Prefix doubling sort followed by the Kasai common-prefix pass
    function automatic void build_index();
        int n;
        int nb;
        int i;
        int k;
        int t;
        int n_dist;
        int a;
        int b;
        int h;
        int j;
        bit same;
        n  = text_len;
        nb = 256;
        for (i = 0; i < n; i++)
        begin
            rank_of[i] = int'(text_mem[i]);
            order2[i]  = i;
        end
        sort_by_rank(n, nb);
        for (k = 1; k < n; k = k << 1)
        begin
            t = 0;
            for (i = n - k; i < n; i++)
            begin
                order2[t] = i;
                t++;
            end
            for (i = 0; i < n; i++)
                if (sa_pos[i] >= k)
                begin
                    order2[t] = sa_pos[i] - k;
                    t++;
                end
            sort_by_rank(n, nb);
            for (i = 0; i < n; i++)
                order2[i] = rank_of[i];
            n_dist = 1;
            rank_of[sa_pos[0]] = 0;
            for (i = 1; i < n; i++)
            begin
                a    = sa_pos[i - 1];
                b    = sa_pos[i];
                same = order2[a] == order2[b];
                if (same)
                begin
                    if ((a + k < n) != (b + k < n))
                        same = 0;
                    else if (a + k < n && order2[a + k] != order2[b + k])
                        same = 0;
                end
                if (same)
                    rank_of[b] = n_dist - 1;
                else
                begin
                    rank_of[b] = n_dist;
                    n_dist++;
                end
            end
            if (n_dist >= n)
                break;
            nb = n_dist;
        end
        for (i = 0; i < n; i++)
            rank_of[sa_pos[i]] = i;
        lcp_of[0] = 0;
        h = 0;
        for (i = 0; i < n; i++)
        begin
            if (h != 0)
                h--;
            if (rank_of[i] == 0)
                continue;
            j = sa_pos[rank_of[i] - 1];
            while (i + h < n && j + h < n && text_mem[i + h] == text_mem[j + h])
                h++;
            lcp_of[rank_of[i]] = h;
        end
        text_built = 1;
    endfunction

    // Advance the predictor by one accepted word; returns 1 when a result is due
    function automatic bit predict_word(input logic op, input logic [SYM_W-1:0] sym,
                                        input logic last, input logic [RANK_W-1:0] rank,
                                        output entry_t res);
        res = '{start: '0, prefix: '0, oor: 1'b1};
        if (op == OP_LOAD)
        begin
            if (text_built)
            begin
                text_built = 0;
                text_len   = 0;
            end
            if (text_len < TEXT_CAP)
            begin
                text_mem[text_len] = sym;
                text_len++;
            end
            if (last)
                build_index();
            return 0;
        end
        if (text_built && int'(rank) < text_len)
        begin
            res.start  = sa_pos[rank][START_W-1:0];
            res.prefix = lcp_of[rank][PREFIX_W-1:0];
            res.oor    = 1'b0;
        end
        return 1;
    endfunction

    // Offer one word, wait for acceptance, then queue what it should produce
    task automatic send_word(input logic op, input logic [SYM_W-1:0] sym,
                             input logic last, input logic [RANK_W-1:0] rank,
                             input bit typed, input entry_t want);
        entry_t res;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        symbol      <= sym;
        last_symbol <= last;
        read_rank   <= rank;
        do
            @(posedge clk);
        while (in_stall);
        if (predict_word(op, sym, last, rank, res))
            pending_entries.push_back(typed ? want : res);
        words_sent++;
    endtask

    task automatic load_sym(input logic [SYM_W-1:0] sym, input logic last);
        send_word(OP_LOAD, sym, last, RANK_W'($urandom_range(1023)), 0, '{default: '0});
    endtask

    task automatic read_at(input int rank);
        send_word(OP_READ, SYM_W'($urandom_range(255)), 1'($urandom_range(1)),
                  rank[RANK_W-1:0], 0, '{default: '0});
    endtask

    // Drop valid and hold until every queued result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_entries.size() != 0)
            @(posedge clk);
    endtask

    // One random text: mostly a well-formed load run then reads, with some noise
    task automatic random_text(input int max_len);
        int len;
        int base;
        int narrow;
        int i;
        len    = $urandom_range(100) < 85 ? $urandom_range(1, 24) : $urandom_range(25, max_len);
        narrow = $urandom_range(1);
        base   = $urandom_range(252);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 5)
                read_at($urandom_range(1023));
            load_sym(SYM_W'(narrow ? base + $urandom_range(3) : $urandom_range(255)),
                     i == len - 1);
        end
        repeat ($urandom_range(len, len + 4))
        begin
            if ($urandom_range(99) < 10)
                read_at($urandom_range(1023));
            else
                read_at($urandom_range(len + 1));
        end
    endtask

    // Receiver: check accepted results and pick the stall for the next cycle
    always @(posedge clk)
    begin
        entry_t exp_e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_entries.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result start=%0d prefix=%0d oor=%0d", $time,
                         suffix_start, common_prefix, out_of_range);
            end
            else
            begin
                exp_e = pending_entries.pop_front();
                if (suffix_start !== exp_e.start)
                begin
                    errors++;
                    $display("%0t: suffix_start expected %0d actual %0d", $time,
                             exp_e.start, suffix_start);
                end
                if (common_prefix !== exp_e.prefix)
                begin
                    errors++;
                    $display("%0t: common_prefix expected %0d actual %0d", $time,
                             exp_e.prefix, common_prefix);
                end
                if (out_of_range !== exp_e.oor)
                begin
                    errors++;
                    $display("%0t: out_of_range expected %0d actual %0d", $time,
                             exp_e.oor, out_of_range);
                end
            end
        end
        if (hold_req != 0)
        begin
            hold_req  = 0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= $urandom_range(99) < recv_stall_pct;
    end

    initial
    begin
        #40ms;
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        row_t  dir_rows [$];
        int    idle_tab  [4];
        int    stall_tab [4];
        int    ph;
        int    i;
        entry_t no_hit;

        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_LOAD;
        symbol         = '0;
        last_symbol    = 1'b0;
        read_rank      = '0;
        out_stall      = 1'b0;
        errors         = 0;
        words_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        hold_left      = 0;
        text_len       = 0;
        text_built     = 0;
        no_hit         = '{start: '0, prefix: '0, oor: 1'b1};

        // Directed table: reads before any build, byte extremes, restart after a
        // build, single-symbol text, a run of equal bytes, last flag on a read.
        dir_rows = '{
            '{OP_READ, 8'd0,   1'b0, 10'd0,    1, no_hit},
            '{OP_READ, 8'd0,   1'b1, 10'd1023, 1, no_hit},
            '{OP_LOAD, 8'd0,   1'b0, 10'd0,    0, no_hit},
            '{OP_LOAD, 8'd255, 1'b0, 10'd0,    0, no_hit},
            '{OP_LOAD, 8'd0,   1'b0, 10'd0,    0, no_hit},
            '{OP_LOAD, 8'd255, 1'b1, 10'd0,    0, no_hit},
            '{OP_READ, 8'd0,   1'b0, 10'd0,    0, no_hit},
            '{OP_READ, 8'd0,   1'b0, 10'd1,    0, no_hit},
            '{OP_READ, 8'd0,   1'b0, 10'd3,    0, no_hit},
            '{OP_READ, 8'd0,   1'b0, 10'd4,    1, no_hit},
            '{OP_READ, 8'd0,   1'b0, 10'd1023, 1, no_hit},
            '{OP_LOAD, 8'd97,  1'b1, 10'd0,    0, no_hit},
            '{OP_READ, 8'd0,   1'b0, 10'd0,    1, '{start: '0, prefix: '0, oor: 1'b0}},
            '{OP_READ, 8'd0,   1'b0, 10'd1,    1, no_hit},
            '{OP_LOAD, 8'd7,   1'b0, 10'd0,    0, no_hit},
            '{OP_LOAD, 8'd7,   1'b0, 10'd0,    0, no_hit},
            '{OP_LOAD, 8'd7,   1'b0, 10'd0,    0, no_hit},
            '{OP_LOAD, 8'd7,   1'b1, 10'd0,    0, no_hit},
            '{OP_READ, 8'd0,   1'b0, 10'd0,    0, no_hit},
            '{OP_READ, 8'd0,   1'b0, 10'd1,    0, no_hit},
            '{OP_READ, 8'd0,   1'b0, 10'd2,    0, no_hit},
            '{OP_READ, 8'd255, 1'b1, 10'd3,    0, no_hit},
            '{OP_READ, 8'd0,   1'b1, 10'd2,    0, no_hit}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
            send_word(dir_rows[r].op, dir_rows[r].sym, dir_rows[r].last,
                      dir_rows[r].rank, dir_rows[r].typed, dir_rows[r].want);
        drain();

        // Full store plus overflow: the last two bytes are dropped, yet the
        // final one still triggers the build over the stored text.
        for (i = 0; i < TEXT_CAP + 2; i++)
            load_sym(SYM_W'(i < 512 ? $urandom_range(255) : $urandom_range(2)),
                     i == TEXT_CAP + 1);
        read_at(0);
        read_at(TEXT_CAP - 1);
        read_at(512);
        // Long receiver hold while reads keep coming, so the block backs up
        hold_req = 1;
        repeat (30)
            read_at($urandom_range(1023));
        drain();

        idle_tab  = '{0, 49, 0, 16};
        stall_tab = '{0, 0, 49, 16};
        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = idle_tab[ph];
            recv_stall_pct = stall_tab[ph];
            while (words_sent < TEXT_CAP + 60 + (ITEM_GOAL - TEXT_CAP - 60) * (ph + 1) / 4)
                random_text(64);
            drain();
        end

        // Let the last result settle, with a bound on the wait
        i = 0;
        while (pending_entries.size() != 0 && i < 10000)
        begin
            @(posedge clk);
            i++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_entries.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
src/salcp_pkg.sv
src/salcp_ctrl.sv
src/salcp_datapath.sv
src/suffix_array_lcp_builder_top.sv
tb/tb_top.sv
